// ===== hdl/lkvc_pkg.sv =====
package lkvc_pkg;

  // default sizes of the store
  localparam int DEF_ENTRIES    = 8;
  localparam int DEF_KEY_BITS   = 16;
  localparam int DEF_VALUE_BITS = 32;

  // capacity register
  localparam int          CAP_BITS  = 4;
  localparam int unsigned CAP_RESET = 8;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // one strobe per datapath step
  typedef struct packed {
    logic load;  // capture the input word
    logic cmp;   // compare key against every entry
    logic sel;   // pick hit data, eviction set and free slot
    logic upd;   // write back ranks and entries, load result
  } lkvc_cmd_t;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// fully associative key/value cache with least-recently-used replacement.
// each input word is a lookup (op 0) or an insert (op 1). a lookup hit returns
// hit=1 and the stored value and makes the entry most recent; a miss, and every
// insert, returns hit=0 and value 0. an insert of a present key overwrites its
// value and makes it most recent; an insert of a new key first evicts the least
// recent entries when the store holds the capacity, then fills the lowest free
// entry. exactly one result word per input word, in order. each word passes
// through accept, key compare, select and write back before the next is accepted,
// set by the controller sequence over the single entry store;
// the write back waits while an earlier result is still held on the output,
// and a new word is accepted while a finished result waits to be taken.
// capacity (cfg_wdata, written with cfg_we while idle) is clamped to
// 1..ENTRIES; lowering it below the fill level keeps entries hittable until
// the next insert of a new key trims the store to the capacity.
module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata,
  // request word
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [VALUE_BITS-1:0]         in_value,
  // result word
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [VALUE_BITS-1:0]         out_read_value
);

  lkvc_pkg::lkvc_cmd_t cmd;

  // sequencer: accept, compare, select, write back
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // entry store, compare cells, rank update and result register
  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

endmodule

// ===== hdl/lkvc_ctrl.sv =====
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lkvc_pkg::lkvc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register can take a new word this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (slot_free) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_upd_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (!out_valid_r || out_ready))
    else $error("result overwritten while waiting");

  a_accept_starts_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CMP))
    else $error("accepted word did not start compare");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped before it was taken");

endmodule

// ===== hdl/lkvc_datapath.sv =====
module lkvc_datapath #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkvc_pkg::lkvc_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata,
  input  logic                          in_op,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_hit,
  output logic [VALUE_BITS-1:0]         out_read_value
);

  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int RANK_W = $clog2(ENTRIES);
  localparam logic [CNT_W-1:0] CAP_INIT =
    CNT_W'((lkvc_pkg::CAP_RESET > ENTRIES) ? ENTRIES : lkvc_pkg::CAP_RESET);

  // entry store
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_q  [ENTRIES];
  logic [VALUE_BITS-1:0] val_q  [ENTRIES];
  logic [RANK_W-1:0]     rank_q [ENTRIES];

  logic [CNT_W-1:0] cap_r, cap_wr, cap_m1, occ_r;

  // captured input word
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;

  // step results
  logic [ENTRIES-1:0]    match_r, match_nxt;
  logic                  found_r, full_r, full_nxt;
  logic [RANK_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic [VALUE_BITS-1:0] hit_val_r, hit_val_nxt;
  logic [ENTRIES-1:0]    evict_r, evict_nxt;
  logic [ENTRIES-1:0]    slot_r, slot_nxt, free_vec;

  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_val_r;

  // clamp capacity into 1..ENTRIES when written
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_wr = CNT_W'(1);
    end else if (int'(cfg_wdata) > ENTRIES) begin
      cap_wr = CNT_W'(ENTRIES);
    end else begin
      cap_wr = CNT_W'(cfg_wdata);
    end
  end

  assign cap_m1   = cap_r - CNT_W'(1);
  assign full_nxt = (occ_r >= cap_r);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (key_q[i] == key_r);
    end
  end

  // and-or select over the one-hot match, eviction mask, first free slot
  always_comb begin
    hit_rank_nxt = '0;
    hit_val_nxt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank_nxt = hit_rank_nxt | (rank_q[i] & {RANK_W{match_r[i]}});
      hit_val_nxt  = hit_val_nxt  | (val_q[i]  & {VALUE_BITS{match_r[i]}});
      evict_nxt[i] = valid_r[i] && full_nxt && (CNT_W'(rank_q[i]) >= cap_m1);
    end
    free_vec = ~(valid_r & ~evict_nxt);
    slot_nxt = free_vec & (~free_vec + ENTRIES'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      key_r  <= in_key;
      wval_r <= in_value;
    end
    if (cmd.cmp) begin
      match_r <= match_nxt;
    end
    if (cmd.sel) begin
      found_r    <= |match_r;
      full_r     <= full_nxt;
      hit_rank_r <= hit_rank_nxt;
      hit_val_r  <= hit_val_nxt;
      evict_r    <= evict_nxt;
      slot_r     <= slot_nxt;
    end
    if (cmd.upd) begin
      out_hit_r <= found_r && (op_r == lkvc_pkg::OP_LOOKUP);
      out_val_r <= (found_r && (op_r == lkvc_pkg::OP_LOOKUP)) ? hit_val_r : '0;
    end
  end

  // per-entry write back: rank aging, eviction, fill
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (found_r) begin
          if (match_r[i]) begin
            rank_q[i] <= '0;
            if (op_r == lkvc_pkg::OP_INSERT) begin
              val_q[i] <= wval_r;
            end
          end else if (valid_r[i] && (rank_q[i] < hit_rank_r)) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end else if (op_r == lkvc_pkg::OP_INSERT) begin
          if (slot_r[i]) begin
            key_q[i]  <= key_r;
            val_q[i]  <= wval_r;
            rank_q[i] <= '0;
          end else if (valid_r[i] && !evict_r[i]) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_INIT;
    end else begin
      if (cfg_we) begin
        cap_r <= cap_wr;
      end
      if (cmd.upd && !found_r && (op_r == lkvc_pkg::OP_INSERT)) begin
        valid_r <= (valid_r & ~evict_r) | slot_r;
        occ_r   <= full_r ? cap_r : (occ_r + CNT_W'(1));
      end
    end
  end

  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sel |-> $onehot0(match_r))
    else $error("key stored in more than one entry");

  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy out of step with valid entries");

  a_fill_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && !found_r && (op_r == lkvc_pkg::OP_INSERT)) |-> $onehot(slot_r))
    else $error("insert miss without exactly one free slot");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES    = lkvc_pkg::DEF_ENTRIES;
  localparam int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS;
  localparam int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int PHASES           = 6;
  localparam int WORDS_PER_PHASE  = 75;
  localparam int RECV_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 16;
  localparam int QUIET_LIMIT      = 2000;  // cycles with no handshake at all
  localparam int MAX_KEY_POOL     = 12;
  localparam int DUE_DEPTH        = 16;    // far more than the cache can hold in flight

  // idling per mode: sender mostly busy first, then receiver, then both never idle
  localparam int SENDER_IDLE_PCT [3] = '{25, 83, 0};
  localparam int RECV_IDLE_PCT   [3] = '{83, 25, 0};
  // capacity per random phase; the last one is drawn at random
  localparam int PHASE_CAPS [PHASES] = '{8, 1, 15, 0, 3, 8};

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
  } result_t;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

  // one line of the directed script; value carries the capacity on ROW_CAP lines
  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic                  fixed;       // expected result given below
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
  } script_row_t;

  localparam int SCRIPT_ROWS = 30;

  // capacity 8 after reset; keys 0 and ffff exercise the key extremes
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // empty store misses
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'hffff, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    // value extremes in, then read back
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0000, 32'hffff_ffff, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'hffff, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
    // lookup value field is ignored
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'hffff, 32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000},
    // insert of a present key overwrites in place
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0000, 32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
    // fill the store, then one more new key evicts the oldest
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0001, 32'ha5a5_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0002, 32'ha5a5_0002, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0003, 32'ha5a5_0003, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0004, 32'ha5a5_0004, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0005, 32'ha5a5_0005, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0006, 32'ha5a5_0006, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0007, 32'ha5a5_0007, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'hffff, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // capacity below fill level: old entries still hit until a new key trims
    '{ROW_CAP,  lkvc_pkg::OP_LOOKUP, 16'h0000, 32'd2,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h8000, 32'h8000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // capacity zero acts as one
    '{ROW_CAP,  lkvc_pkg::OP_LOOKUP, 16'h0000, 32'd0,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h00ff, 32'h00ff_00ff, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'hff00, 32'hff00_ff00, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h00ff, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'hff00, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // capacity above the entry count saturates
    '{ROW_CAP,  lkvc_pkg::OP_LOOKUP, 16'h0000, 32'd15,        1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0aaa, 32'h5555_aaaa, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_INSERT, 16'h0555, 32'haaaa_5555, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_WORD, lkvc_pkg::OP_LOOKUP, 16'h0aaa, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CAP,  lkvc_pkg::OP_LOOKUP, 16'h0000, 32'd8,         1'b0, 1'b0, 32'h0000_0000}
  };

  // dut ports, the inputs all known from time zero
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [lkvc_pkg::CAP_BITS-1:0]   cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_op = lkvc_pkg::OP_LOOKUP;
  logic [KEY_BITS-1:0]             in_key = '0;
  logic [VALUE_BITS-1:0]           in_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_hit;
  logic [VALUE_BITS-1:0]           out_read_value;

  // directed rows with a result typed in travel alongside the payload
  logic                  word_fixed = 1'b0;
  logic                  fixed_hit = 1'b0;
  logic [VALUE_BITS-1:0] fixed_read_value = '0;

  // pacing knobs set by the stimulus process
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;   // bumped to ask the receiver for one long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // predicted cache contents
  bit                            line_valid [ENTRIES];
  bit [KEY_BITS-1:0]             line_key   [ENTRIES];
  bit [VALUE_BITS-1:0]           line_value [ENTRIES];
  int unsigned                   line_age   [ENTRIES];  // 0 is most recent
  int unsigned                   line_fill;
  bit [lkvc_pkg::CAP_BITS-1:0]   cache_cap;

  // expected result words in order, as a ring
  result_t due_fifo [DUE_DEPTH];
  int      due_head = 0;
  int      due_tail = 0;
  int      due_count = 0;

  int mismatches = 0;
  int lookups = 0;
  int lookup_hits = 0;
  int inserts = 0;
  int evictions = 0;
  int cap_writes = 0;

  always #CLK_HALF clk = ~clk;

  lru_key_value_cache #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_value(out_read_value)
  );

  // one cache access against the predicted contents, returns the result word
  function automatic result_t lru_access(input logic op, input logic [KEY_BITS-1:0] k,
                                         input logic [VALUE_BITS-1:0] v);
    result_t     res;
    int          found;
    int          slot;
    int unsigned eff_cap;
    int unsigned old_age;
    res = '0;
    found = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && line_valid[i] && line_key[i] == k) found = i;
    end
    if (op == lkvc_pkg::OP_LOOKUP) lookups++;
    else inserts++;
    if (found >= 0) begin
      // hit or overwrite: younger entries age by one, this one becomes newest
      old_age = line_age[found];
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && i != found && line_age[i] < old_age) line_age[i]++;
      end
      line_age[found] = 0;
      if (op == lkvc_pkg::OP_LOOKUP) begin
        res.hit = 1'b1;
        res.read_value = line_value[found];
        lookup_hits++;
      end else begin
        line_value[found] = v;
      end
    end else if (op == lkvc_pkg::OP_INSERT) begin
      eff_cap = (cache_cap == 0) ? 1 : (cache_cap > ENTRIES) ? ENTRIES : cache_cap;
      // full (or over a lowered capacity): drop everything at or past the cap
      if (line_fill >= eff_cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && line_age[i] >= eff_cap - 1) begin
            line_valid[i] = 1'b0;
            line_fill--;
            evictions++;
          end
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i]) line_age[i]++;
        else if (slot < 0) slot = i;
      end
      if (slot >= 0) begin
        line_valid[slot] = 1'b1;
        line_key[slot] = k;
        line_value[slot] = v;
        line_age[slot] = 0;
        line_fill++;
      end
    end
    return res;
  endfunction

  // scoreboard: results checked before the same edge's request is predicted
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_age[i] = 0;
      end
      line_fill = 0;
      cache_cap = lkvc_pkg::CAP_RESET[lkvc_pkg::CAP_BITS-1:0];
      due_head = 0;
      due_tail = 0;
      due_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_count == 0) begin
          $error("result word with nothing outstanding: hit %0b read_value %h",
                 out_hit, out_read_value);
          mismatches++;
        end else begin
          want = due_fifo[due_head];
          due_head = (due_head + 1) % DUE_DEPTH;
          due_count--;
          if (out_hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, out_hit);
            mismatches++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, out_read_value);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        cache_cap = cfg_wdata;
        cap_writes++;
      end
      if (in_valid && in_ready) begin
        want = lru_access(in_op, in_key, in_value);
        if (word_fixed) begin
          want.hit = fixed_hit;
          want.read_value = fixed_read_value;
        end
        if (due_count == DUE_DEPTH) begin
          $error("more than %0d result words outstanding", DUE_DEPTH);
          mismatches++;
        end else begin
          due_fifo[due_tail] = want;
          due_tail = (due_tail + 1) % DUE_DEPTH;
          due_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= RECV_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cycles, due_count);
      $display("FAIL lru_key_value_cache");
      $finish;
    end
  end

  // offer one request word and hold it until accepted
  task automatic send_word(input logic op, input logic [KEY_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v, input logic fixed,
                           input logic hit, input logic [VALUE_BITS-1:0] rv);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= k;
    in_value <= v;
    word_fixed <= fixed;
    fixed_hit <= hit;
    fixed_read_value <= rv;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  // capacity only changes while the cache is idle
  task automatic write_capacity(input logic [lkvc_pkg::CAP_BITS-1:0] cap);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [KEY_BITS-1:0] key_pool [MAX_KEY_POOL];
    int                  pool_size;
    logic                op;
    logic [KEY_BITS-1:0] k;
    int                  cap;

    sender_idle_pct = SENDER_IDLE_PCT[0];
    recv_idle_pct = RECV_IDLE_PCT[0];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CAP) begin
        write_capacity(SCRIPT[i].value[lkvc_pkg::CAP_BITS-1:0]);
      end else begin
        send_word(SCRIPT[i].op, SCRIPT[i].key, SCRIPT[i].value,
                  SCRIPT[i].fixed, SCRIPT[i].hit, SCRIPT[i].read_value);
      end
    end

    // random phases: a small key pool per phase keeps hits and evictions frequent
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = SENDER_IDLE_PCT[ph / 2];
      recv_idle_pct = RECV_IDLE_PCT[ph / 2];
      cap = (ph == PHASES - 1) ? $urandom_range(15) : PHASE_CAPS[ph];
      write_capacity(cap[lkvc_pkg::CAP_BITS-1:0]);
      pool_size = $urandom_range(MAX_KEY_POOL, 3);
      foreach (key_pool[j]) key_pool[j] = KEY_BITS'($urandom_range(16'hffff));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // long receiver hold-off while words keep coming, so the input backs up
        if (ph == 4 && n == 10) hold_token <= hold_token + 1;
        // sender pause until everything has come back
        if (ph == 2 && n == 40) drain_results();
        op = ($urandom_range(1) == 0) ? lkvc_pkg::OP_LOOKUP : lkvc_pkg::OP_INSERT;
        k = ($urandom_range(9) == 0) ? KEY_BITS'($urandom_range(16'hffff))
                                     : key_pool[$urandom_range(pool_size - 1)];
        send_word(op, k, VALUE_BITS'($urandom), 1'b0, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_count != 0) begin
      $error("%0d expected result words never arrived", due_count);
    end

    $display("covered %0d lookups (%0d hits) and %0d inserts (%0d evictions)",
             lookups, lookup_hits, inserts, evictions);
    $display("over %0d capacity writes, with stalls on both sides and one long back-up",
             cap_writes);
    if (mismatches == 0 && due_count == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

endmodule

// ===== lru_key_value_cache.f =====
hdl/lkvc_pkg.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_datapath.sv
hdl/lru_key_value_cache.sv
tb/testbench.sv
